// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the bridge RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/i2cb_pkg.sv -----
// Shared types and constants for the I2C line-to-byte bridge.
// No dependencies; used by i2cb_decoder and i2c_line_to_byte_bridge.
`timescale 1ns / 1ps

package i2cb_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // transfer_mode codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_ADDR  = 2'd2;

  localparam logic [3:0] BIT_ACK_DRIVE = 4'd8;
  localparam logic [3:0] BIT_ACK_SAMPLE = 4'd9;

  // First field in the highest bits: members listed from MSB down.
  typedef struct packed {
    logic [7:0] device_read_data;
    logic       device_ack;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_readback;
    logic       sda_readback;
    logic [7:0] written_byte;
    logic       direction_read;
    logic [6:0] target_address;
    logic       stop_request;
    logic       read_request;
    logic       write_request;
    logic       start_request;
  } out_item_t;

  localparam int IN_BITS  = $bits(in_item_t);
  localparam int OUT_BITS = $bits(out_item_t);
  localparam int OUT_PAD  = OUT_TDATA_W - OUT_BITS;

  typedef struct packed {
    logic       last_scl;
    logic       last_sda;
    logic       slave_drive;
    logic       in_transfer;
    logic       address_valid;
    logic [6:0] device_address;
    logic [1:0] transfer_mode;
    logic       addr_marker;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
  } bus_state_t;

  localparam bus_state_t STATE_RESET = '{
    last_scl:       1'b1,
    last_sda:       1'b1,
    slave_drive:    1'b1,
    in_transfer:    1'b0,
    address_valid:  1'b0,
    device_address: 7'd0,
    transfer_mode:  MODE_WRITE,
    addr_marker:    1'b0,
    bit_count:      4'd0,
    shift_byte:     8'd0
  };

endpackage

// ----- rtl/core/i2cb_decoder.sv -----
// Bus state tracker: start/stop detect, bit shifting and device requests.
// Depends on i2cb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cb_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  i2cb_pkg::in_item_t  item,
  output i2cb_pkg::out_item_t result
);

  i2cb_pkg::bus_state_t state;
  i2cb_pkg::bus_state_t state_next;

  always_comb begin
    i2cb_pkg::bus_state_t nx;
    logic       plain_read;
    logic       req_start;
    logic       req_write;
    logic       req_read;
    logic       req_stop;
    logic [7:0] wbyte;
    logic [3:0] cnt;

    nx         = state;
    plain_read = !state.addr_marker && (state.transfer_mode == i2cb_pkg::MODE_READ);
    req_start  = 1'b0;
    req_write  = 1'b0;
    req_read   = 1'b0;
    req_stop   = 1'b0;
    wbyte      = 8'd0;
    cnt        = state.bit_count + 4'd1;

    priority if (state.last_scl && item.scl_in) begin
      priority if (state.last_sda && !item.sda_in) begin
        // start condition
        nx.in_transfer   = 1'b1;
        nx.bit_count     = 4'd0;
        nx.address_valid = 1'b0;
        nx.transfer_mode = i2cb_pkg::MODE_ADDR;
        nx.addr_marker   = 1'b0;
        nx.slave_drive   = 1'b1;
      end else if (!state.last_sda && item.sda_in) begin
        // stop condition
        nx.in_transfer   = 1'b0;
        req_stop         = state.address_valid;
        nx.address_valid = 1'b0;
        nx.slave_drive   = 1'b1;
      end else begin
      end
    end else if (!state.last_scl && item.scl_in && state.in_transfer) begin
      nx.bit_count = cnt;
      if (state.bit_count < 4'd8) begin
        if (plain_read) begin
          nx.slave_drive = state.shift_byte[7];
          nx.shift_byte  = {state.shift_byte[6:0], 1'b0};
        end else begin
          nx.shift_byte  = {state.shift_byte[6:0], item.sda_in};
        end
      end
      priority if (cnt == i2cb_pkg::BIT_ACK_DRIVE) begin
        priority if (!state.addr_marker && state.transfer_mode == i2cb_pkg::MODE_ADDR) begin
          nx.device_address = nx.shift_byte[7:1];
          nx.address_valid  = 1'b1;
          nx.transfer_mode  = {1'b0, nx.shift_byte[0]};
          req_start         = 1'b1;
          nx.slave_drive    = !item.device_ack;
          if (item.device_ack && nx.shift_byte[0]) begin
            req_read      = 1'b1;
            nx.shift_byte = item.device_read_data;
          end
          nx.addr_marker    = 1'b1;
        end else if (!state.addr_marker && state.transfer_mode == i2cb_pkg::MODE_WRITE) begin
          req_write      = 1'b1;
          wbyte          = nx.shift_byte;
          nx.slave_drive = !item.device_ack;
        end else begin
        end
      end else if (cnt == i2cb_pkg::BIT_ACK_SAMPLE) begin
        if (plain_read) begin
          // master ack fetches the next byte
          if (!item.sda_in) begin
            req_read      = 1'b1;
            nx.shift_byte = item.device_read_data;
          end
        end else begin
          nx.addr_marker   = 1'b0;
          nx.transfer_mode = {1'b0, state.transfer_mode[0]};
        end
        nx.bit_count = 4'd0;
      end else begin
      end
    end else if (state.last_scl && !item.scl_in && state.bit_count != i2cb_pkg::BIT_ACK_DRIVE) begin
      nx.slave_drive = 1'b1;
    end else begin
    end

    nx.last_scl = item.scl_in;
    nx.last_sda = item.sda_in;
    state_next  = nx;

    result.start_request  = req_start;
    result.write_request  = req_write;
    result.read_request   = req_read;
    result.stop_request   = req_stop;
    result.target_address = req_stop ? state.device_address :
                            (nx.address_valid ? nx.device_address : 7'd0);
    result.direction_read = (nx.transfer_mode == i2cb_pkg::MODE_READ);
    result.written_byte   = wbyte;
    result.sda_readback   = item.sda_in & nx.slave_drive;
    result.scl_readback   = item.scl_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2cb_pkg::STATE_RESET;
    end else if (step) begin
      state <= state_next;
    end
  end

  `ASSERT_ALWAYS(a_bit_count_range, clk, rst, state.bit_count <= i2cb_pkg::BIT_ACK_SAMPLE,
    "bit counter ran past the ack bit")
  `ASSERT_IMPLY(a_one_request, clk, rst, step,
    $onehot0({result.start_request, result.write_request, result.stop_request}),
    "start, write and stop requested together")
  `ASSERT_NEXT(a_start_opens, clk, rst,
    step && state.last_scl && item.scl_in && state.last_sda && !item.sda_in,
    state.in_transfer && state.transfer_mode == i2cb_pkg::MODE_ADDR,
    "start condition did not open an address phase")

endmodule

// ----- rtl/core/i2c_line_to_byte_bridge.sv -----
// I2C line-to-byte bridge: top level with input and result registers.
// Each beat passes the input register, then the result register. Throughput: one
// beat per cycle unless m_axis stalls; input register refills while a result waits.
// Reset (rst, synchronous, active high): bus state returns to idle with lines
// released, both stages empty. Depends on i2cb_pkg, i2cb_decoder, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_line_to_byte_bridge (
  input  logic                              clk,
  input  logic                              rst,
  // slave side: one line sample per beat
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] scl_in, [1] sda_in, [2] device_ack, [10:3] device_read_data, rest zero
  input  logic [i2cb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // master side: one result per beat
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] start_request, [1] write_request, [2] read_request, [3] stop_request,
  // [10:4] target_address, [11] direction_read, [19:12] written_byte,
  // [20] sda_readback, [21] scl_readback, rest zero
  output logic [i2cb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // Stage 1: captured line sample.
  logic                in_valid;
  i2cb_pkg::in_item_t  in_item;

  // Stage 2: result register.
  i2cb_pkg::out_item_t out_item;
  i2cb_pkg::out_item_t result;

  logic advance;  // result register free or draining this cycle
  logic step;     // stage 1 beat moves into the result register

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (step) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= i2cb_pkg::in_item_t'(s_axis_tdata[i2cb_pkg::IN_BITS-1:0]);
    end
    if (step) begin
      out_item <= result;
    end
  end

  // Bus state only moves when a sample is committed to the result register,
  // so stalls on the master side never skip or repeat an edge.
  i2cb_decoder u_decoder (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (result)
  );

  assign m_axis_tdata = {{i2cb_pkg::OUT_PAD{1'b0}}, out_item};

  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready,
    "input stalled with an empty result register")
  `ASSERT_NEXT(a_step_fills_output, clk, rst, step, m_axis_tvalid,
    "committed sample produced no result beat")

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the I2C line-to-byte bridge: bit-banged bus traffic in,
// per-sample decoder results out, checked against an in-bench decoder model.
// Depends on i2cb_pkg and the i2c_line_to_byte_bridge RTL.
`timescale 1ns / 1ps

module tb;

  localparam int LIMIT_CYCLES = 200000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [i2cb_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [i2cb_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  i2c_line_to_byte_bridge dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // line samples waiting to be sent, and decoder results still owed by the DUT
  i2cb_pkg::in_item_t  line_q[$];
  i2cb_pkg::out_item_t predicted_q[$];

  int n_items;
  int in_cnt = 0;
  int out_cnt = 0;
  int err_cnt = 0;
  int cycles = 0;
  int stretch_pct = 0;

  // last stretch of the run goes without any idling on either side
  wire calm = (in_cnt + 150 >= n_items);

  // ---------------------------------------------------------------------------
  // Decoder model: bus-side state of the bridge
  // ---------------------------------------------------------------------------
  logic       bus_scl, bus_sda, bus_drive, bus_busy, bus_addr_ok, bus_marker;
  logic [6:0] bus_addr;
  logic [1:0] bus_mode;
  logic [3:0] bus_bits;
  logic [7:0] bus_shift;

  task automatic reset_decoder();
    bus_scl     = 1'b1;
    bus_sda     = 1'b1;
    bus_drive   = 1'b1;   // released
    bus_busy    = 1'b0;
    bus_addr_ok = 1'b0;
    bus_marker  = 1'b0;
    bus_addr    = '0;
    bus_mode    = i2cb_pkg::MODE_WRITE;
    bus_bits    = '0;
    bus_shift   = '0;
  endtask

  // One line sample in, one decoder result out.
  function automatic i2cb_pkg::out_item_t decode_sample(input i2cb_pkg::in_item_t s);
    i2cb_pkg::out_item_t r;
    logic                plain_rd;
    logic                stopped;
    logic [6:0]          stop_addr;
    logic [3:0]          prev;
    r         = '0;
    stopped   = 1'b0;
    stop_addr = '0;
    // mode as it stood before this sample decides shift-in vs shift-out
    plain_rd  = !bus_marker && (bus_mode == i2cb_pkg::MODE_READ);

    if (bus_scl && s.scl_in) begin
      if (bus_sda && !s.sda_in) begin
        // start: fresh address byte follows
        bus_busy    = 1'b1;
        bus_bits    = '0;
        bus_addr_ok = 1'b0;
        bus_mode    = i2cb_pkg::MODE_ADDR;
        bus_marker  = 1'b0;
        bus_drive   = 1'b1;
      end else if (!bus_sda && s.sda_in) begin
        // stop: only reported when an address was latched
        bus_busy = 1'b0;
        if (bus_addr_ok) begin
          r.stop_request = 1'b1;
          stopped        = 1'b1;
          stop_addr      = bus_addr;
        end
        bus_addr_ok = 1'b0;
        bus_drive   = 1'b1;
      end
    end else if (!bus_scl && s.scl_in && bus_busy) begin
      prev     = bus_bits;
      bus_bits = bus_bits + 4'd1;
      if (prev < i2cb_pkg::BIT_ACK_DRIVE) begin
        if (plain_rd) begin
          bus_drive = bus_shift[7];
          bus_shift = {bus_shift[6:0], 1'b0};
        end else begin
          bus_shift = {bus_shift[6:0], s.sda_in};
        end
      end
      if (bus_bits == i2cb_pkg::BIT_ACK_DRIVE) begin
        if (!bus_marker && bus_mode == i2cb_pkg::MODE_ADDR) begin
          bus_addr        = bus_shift[7:1];
          bus_addr_ok     = 1'b1;
          bus_mode        = {1'b0, bus_shift[0]};
          r.start_request = 1'b1;
          bus_drive       = !s.device_ack;
          if (s.device_ack && bus_mode == i2cb_pkg::MODE_READ) begin
            r.read_request = 1'b1;
            bus_shift      = s.device_read_data;
          end
          bus_marker = 1'b1;
        end else if (!bus_marker && bus_mode == i2cb_pkg::MODE_WRITE) begin
          r.write_request = 1'b1;
          r.written_byte  = bus_shift;
          bus_drive       = !s.device_ack;
        end
      end else if (bus_bits == i2cb_pkg::BIT_ACK_SAMPLE) begin
        if (plain_rd) begin
          // master ack pulls the next byte, nack leaves the shift register alone
          if (!s.sda_in) begin
            r.read_request = 1'b1;
            bus_shift      = s.device_read_data;
          end
        end else begin
          // ninth bit of the address byte just drops the marker
          bus_marker = 1'b0;
          bus_mode   = {1'b0, bus_mode[0]};
        end
        bus_bits = '0;
      end
    end else if (bus_scl && !s.scl_in && bus_bits != i2cb_pkg::BIT_ACK_DRIVE) begin
      bus_drive = 1'b1;
    end

    bus_scl = s.scl_in;
    bus_sda = s.sda_in;

    r.target_address = stopped ? stop_addr : (bus_addr_ok ? bus_addr : 7'd0);
    r.direction_read = (bus_mode == i2cb_pkg::MODE_READ);
    r.sda_readback   = bus_sda & bus_drive;
    r.scl_readback   = bus_scl;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus traffic builders
  // ---------------------------------------------------------------------------
  function automatic logic coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic put_line(input logic scl, input logic sda, input logic ack,
                          input logic [7:0] rdata);
    i2cb_pkg::in_item_t it;
    it.scl_in           = scl;
    it.sda_in           = sda;
    it.device_ack       = ack;
    it.device_read_data = rdata;
    line_q.push_back(it);
  endtask

  // SDA settles while SCL is low, then SCL rises; ack/rdata ride on the rising sample
  task automatic send_bit(input logic b, input logic ack, input logic [7:0] rdata);
    put_line(1'b0, b, coin(50), 8'($urandom));
    if (coin(stretch_pct)) put_line(1'b0, b, coin(50), 8'($urandom));
    put_line(1'b1, b, ack, rdata);
    if (coin(stretch_pct)) put_line(1'b1, b, coin(50), 8'($urandom));
  endtask

  // eight bits MSB first plus the acknowledge bit
  task automatic send_byte(input logic [7:0] b, input logic ninth, input logic ack,
                           input logic [7:0] rdata);
    for (int i = 7; i >= 0; i--)
      send_bit(b[i], (i == 0) ? ack : coin(50), (i == 0) ? rdata : 8'($urandom));
    send_bit(ninth, coin(50), rdata);
  endtask

  // works from any line state: SCL low, SDA up, SCL up, then SDA falls
  task automatic send_start();
    put_line(1'b0, 1'b1, coin(50), 8'($urandom));
    put_line(1'b1, 1'b1, coin(50), 8'($urandom));
    put_line(1'b1, 1'b0, coin(50), 8'($urandom));
  endtask

  task automatic send_stop();
    put_line(1'b0, 1'b0, coin(50), 8'($urandom));
    put_line(1'b1, 1'b0, coin(50), 8'($urandom));
    put_line(1'b1, 1'b1, coin(50), 8'($urandom));
  endtask

  task automatic transfer(input logic [6:0] addr, input logic rd, input int nbytes,
                          input logic do_stop);
    logic [7:0] data;
    logic       nine;
    send_start();
    send_byte({addr, rd}, 1'b1, coin(85), 8'($urandom));
    for (int k = 0; k < nbytes; k++) begin
      if (rd) begin
        // master mostly releases SDA during read data; last byte usually nacked
        data = coin(85) ? 8'hff : 8'($urandom);
        nine = (k == nbytes - 1) ? coin(85) : coin(15);
        send_byte(data, nine, coin(85), 8'($urandom));
      end else begin
        send_byte(8'($urandom), 1'b1, coin(85), 8'($urandom));
      end
    end
    if (do_stop) send_stop();
  endtask

  task automatic build_traffic();
    logic [6:0] addr;
    int         pick;
    int         n;

    // directed: clock edges before any start are ignored
    stretch_pct = 0;
    put_line(1'b0, 1'b1, 1'b1, 8'h00);
    put_line(1'b1, 1'b1, 1'b1, 8'h00);
    put_line(1'b0, 1'b0, 1'b0, 8'hff);
    put_line(1'b1, 1'b0, 1'b0, 8'hff);
    // start directly followed by stop, no address latched
    send_start();
    send_stop();
    // read from the top address, device returns all ones, master nacks the byte
    send_start();
    send_byte({7'h7f, 1'b1}, 1'b1, 1'b1, 8'hff);
    send_byte(8'hff, 1'b1, 1'b1, 8'h00);
    send_stop();

    // random: mostly well-formed transfers, some noise and broken frames
    stretch_pct = 30;
    while (line_q.size() < 950) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) put_line(coin(50), coin(50), coin(50), 8'($urandom));
      end else if (pick == 1) begin
        // frame cut short by a stop or a repeated start
        send_start();
        n = $urandom_range(1, 12);
        repeat (n) send_bit(coin(50), coin(50), 8'($urandom));
        if (coin(50)) send_stop();
      end else begin
        case ($urandom_range(0, 9))
          0:       addr = 7'h00;
          1:       addr = 7'h7f;
          default: addr = 7'($urandom);
        endcase
        transfer(addr, coin(50), $urandom_range(0, 3), coin(80));
      end
    end
    send_stop();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, end of run
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    reset_decoder();
    build_traffic();
    n_items = line_q.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // negedge polling keeps clear of the monitor's queue updates
    do @(negedge clk); while (in_cnt != n_items || predicted_q.size() != 0);
    // any late extra beat in this window is flagged by the monitor
    repeat (20) @(negedge clk);
    if (err_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one line sample per beat, with random idle bursts
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && coin(10)) begin
        gap_left      <= $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else if (line_q.size() != 0) begin
        s_axis_tdata  <= {{(i2cb_pkg::IN_TDATA_W - i2cb_pkg::IN_BITS){1'b0}},
                          line_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off so the DUT backs up
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (!hold_done && out_cnt >= 300) begin
      hold_done     <= 1'b1;
      stall_left    <= 120;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && coin(12)) begin
      stall_left    <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input beats, check on output beats
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    i2cb_pkg::out_item_t got;
    i2cb_pkg::out_item_t want;
    i2cb_pkg::in_item_t  smp;
    if (!rst) begin
      // result first: it always belongs to an earlier input beat
      if (m_axis_tvalid && m_axis_tready) begin
        got     = m_axis_tdata[i2cb_pkg::OUT_BITS-1:0];
        out_cnt <= out_cnt + 1;
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %0h", $time, got);
          err_cnt++;
        end else begin
          want = predicted_q.pop_front();
          check_field("start_request",  want.start_request,  got.start_request);
          check_field("write_request",  want.write_request,  got.write_request);
          check_field("read_request",   want.read_request,   got.read_request);
          check_field("stop_request",   want.stop_request,   got.stop_request);
          check_field("target_address", want.target_address, got.target_address);
          check_field("direction_read", want.direction_read, got.direction_read);
          check_field("written_byte",   want.written_byte,   got.written_byte);
          check_field("sda_readback",   want.sda_readback,   got.sda_readback);
          check_field("scl_readback",   want.scl_readback,   got.scl_readback);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        smp    = s_axis_tdata[i2cb_pkg::IN_BITS-1:0];
        predicted_q.push_back(decode_sample(smp));
        in_cnt <= in_cnt + 1;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/i2cb_pkg.sv
rtl/core/i2cb_decoder.sv
rtl/core/i2c_line_to_byte_bridge.sv
tb/tb.sv
